[hw/rtl/assert_macros.svh]
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define FOC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("formatter assertion failed");

// Checks that a condition never holds outside reset.
`define FOC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("formatter forbidden condition seen");

`endif

[hw/rtl/foc_pkg.sv]
// Types, constants and character helpers of the formatted character stream.
`default_nettype none

package foc_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned DEC_DIGITS = 10;
	localparam int unsigned HEX_DIGITS = 8;
	localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
	localparam int unsigned NULL_LEN   = 6;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd500;

	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

	typedef enum logic [CMD_W-1:0] {
		CMD_LITERAL  = 3'd0,
		CMD_SIGNED   = 3'd1,
		CMD_UNSIGNED = 3'd2,
		CMD_HEX      = 3'd3,
		CMD_CHAR     = 3'd4,
		CMD_UNKNOWN  = 3'd5,
		CMD_NULL     = 3'd6,
		CMD_END      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_BYTE,
		SEL_PERCENT,
		SEL_MINUS,
		SEL_ZERO,
		SEL_X,
		SEL_NULL,
		SEL_DEC,
		SEL_HEX
	} sel_t;

	typedef struct packed {
		logic       load;
		logic       bcd_step;
		logic       emit;
		logic       emit_end;
		logic       final_ch;
		sel_t       sel;
		logic [3:0] idx;
		logic [2:0] pos;
	} foc_ctl_t;

	typedef struct packed {
		logic out_free;
		logic negative;
		logic byte_zero;
		logic digit_zero;
	} foc_sts_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = 8'h30 + {4'h0, d};
		end else begin
			r = 8'h57 + {4'h0, d};
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] null_char(input logic [2:0] p);
		logic [CHAR_W-1:0] r;
		case (p)
			3'd0: r = 8'h28;
			3'd1: r = 8'h6E;
			3'd2: r = 8'h75;
			3'd3: r = 8'h6C;
			3'd4: r = 8'h6C;
			default: r = 8'h29;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/foc_datapath.sv]
// Datapath: argument registers, serial binary-to-BCD converter, count and output register.
`default_nettype none
`include "assert_macros.svh"

module foc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [foc_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic [foc_pkg::CMD_W-1:0]     command,
	input  logic [foc_pkg::VALUE_W-1:0]   value,
	input  logic                          out_ready,
	input  foc_pkg::foc_ctl_t             ctl,
	output foc_pkg::foc_sts_t             sts,
	output logic                          out_valid,
	output logic [foc_pkg::CHAR_W-1:0]    character,
	output logic                          last,
	output logic [foc_pkg::COUNT_W-1:0]   length
);
	import foc_pkg::*;

	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_inc;
	logic               fits;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] shift_q;
	logic [VALUE_W-1:0] mag;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic               neg_q;
	logic [3:0]         dec_dig [DEC_DIGITS];
	logic [3:0]         hex_dig [HEX_DIGITS];
	logic [3:0]         digit;
	logic [CHAR_W-1:0]  ch;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic [COUNT_W-1:0] out_len_q;

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			dec_dig[i] = bcd_q[4*i +: 4];
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
		for (int j = 0; j < HEX_DIGITS; j++) begin
			hex_dig[j] = val_q[4*j +: 4];
		end
	end

	assign digit = (ctl.sel == SEL_HEX) ? hex_dig[ctl.idx[2:0]] : dec_dig[ctl.idx];

	always_comb begin
		case (ctl.sel)
			SEL_BYTE:    ch = val_q[CHAR_W-1:0];
			SEL_PERCENT: ch = CH_PERCENT;
			SEL_MINUS:   ch = CH_MINUS;
			SEL_ZERO:    ch = CH_ZERO;
			SEL_X:       ch = CH_X;
			SEL_NULL:    ch = null_char(ctl.pos);
			SEL_DEC:     ch = hex_char(digit);
			SEL_HEX:     ch = hex_char(digit);
			default:     ch = CH_NUL;
		endcase
	end

	assign count_inc = count_q + 1'b1;
	assign fits      = (count_q < limit_q);
	assign mag       = ((cmd_t'(command) == CMD_SIGNED) && value[VALUE_W-1]) ?
	                   (~value + 32'd1) : value;

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.negative   = neg_q;
	assign sts.byte_zero  = (val_q[CHAR_W-1:0] == '0);
	assign sts.digit_zero = (digit == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (ctl.emit_end) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
			end else if (ctl.emit && fits) begin
				out_valid_q <= 1'b1;
				count_q     <= count_inc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q   <= value;
			shift_q <= mag;
			bcd_q   <= '0;
			neg_q   <= (cmd_t'(command) == CMD_SIGNED) && value[VALUE_W-1];
		end else if (ctl.bcd_step) begin
			bcd_q   <= {bcd_adj[BCD_W-2:0], shift_q[VALUE_W-1]};
			shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
		end
		if (ctl.emit_end) begin
			out_char_q <= CH_NUL;
			out_last_q <= 1'b1;
			out_len_q  <= count_q;
		end else if (ctl.emit && fits) begin
			out_char_q <= ch;
			out_last_q <= ctl.final_ch || (count_inc == limit_q);
			out_len_q  <= count_inc;
		end
	end

	assign out_valid = out_valid_q;
	assign character = out_char_q;
	assign last      = out_last_q;
	assign length    = out_len_q;

	`FOC_ASSERT(a_end_clears, ctl.emit_end |=> (count_q == '0) && out_valid_q && out_last_q)
	`FOC_ASSERT(a_fit_emits, (ctl.emit && fits) |=> out_valid_q && (out_len_q == count_q))

endmodule

`default_nettype wire

[hw/rtl/foc_ctrl.sv]
// Controller: sequences conversion and character emission for one request at a time.
`default_nettype none
`include "assert_macros.svh"

module foc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [foc_pkg::CMD_W-1:0] command,
	input  foc_pkg::foc_sts_t         sts,
	output foc_pkg::foc_ctl_t         ctl
);
	import foc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_MINUS,
		S_HEX0,
		S_HEXX,
		S_DIGITS,
		S_BYTE,
		S_PCT,
		S_NULL,
		S_END
	} state_t;

	localparam logic [4:0] BITS_LAST = 5'(VALUE_W - 1);
	localparam logic [3:0] DEC_LAST  = 4'(DEC_DIGITS - 1);
	localparam logic [3:0] HEX_LAST  = 4'(HEX_DIGITS - 1);
	localparam logic [2:0] NULL_LAST = 3'(NULL_LEN - 1);

	state_t     state_q;
	logic [4:0] bit_q;
	logic [3:0] idx_q;
	logic [2:0] pos_q;
	logic       started_q;
	logic       hex_q;
	logic       accept;
	logic       skip;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign skip     = (state_q == S_DIGITS) && !started_q && sts.digit_zero && (idx_q != 4'd0);

	always_comb begin
		ctl          = '0;
		ctl.load     = accept;
		ctl.bcd_step = (state_q == S_CONV);
		ctl.idx      = idx_q;
		ctl.pos      = pos_q;
		ctl.sel      = SEL_BYTE;
		case (state_q)
			S_MINUS: begin
				ctl.sel  = SEL_MINUS;
				ctl.emit = sts.out_free;
			end
			S_HEX0: begin
				ctl.sel  = SEL_ZERO;
				ctl.emit = sts.out_free;
			end
			S_HEXX: begin
				ctl.sel  = SEL_X;
				ctl.emit = sts.out_free;
			end
			S_DIGITS: begin
				ctl.sel      = hex_q ? SEL_HEX : SEL_DEC;
				ctl.emit     = sts.out_free && !skip;
				ctl.final_ch = (idx_q == 4'd0);
			end
			S_BYTE: begin
				ctl.sel      = SEL_BYTE;
				ctl.emit     = sts.out_free;
				ctl.final_ch = 1'b1;
			end
			S_PCT: begin
				ctl.sel      = SEL_PERCENT;
				ctl.emit     = sts.out_free;
				ctl.final_ch = sts.byte_zero;
			end
			S_NULL: begin
				ctl.sel      = SEL_NULL;
				ctl.emit     = sts.out_free;
				ctl.final_ch = (pos_q == NULL_LAST);
			end
			S_END: begin
				ctl.emit_end = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_q     <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
			started_q <= 1'b0;
			hex_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						started_q <= 1'b0;
						bit_q     <= '0;
						pos_q     <= '0;
						hex_q     <= (cmd_t'(command) == CMD_HEX);
						case (cmd_t'(command))
							CMD_SIGNED, CMD_UNSIGNED: state_q <= S_CONV;
							CMD_HEX:     state_q <= S_HEX0;
							CMD_UNKNOWN: state_q <= S_PCT;
							CMD_NULL:    state_q <= S_NULL;
							CMD_END:     state_q <= S_END;
							default:     state_q <= S_BYTE;
						endcase
					end
				end
				S_CONV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == BITS_LAST) begin
						idx_q   <= DEC_LAST;
						state_q <= sts.negative ? S_MINUS : S_DIGITS;
					end
				end
				S_MINUS: begin
					if (sts.out_free) begin
						state_q <= S_DIGITS;
					end
				end
				S_HEX0: begin
					if (sts.out_free) begin
						state_q <= S_HEXX;
					end
				end
				S_HEXX: begin
					if (sts.out_free) begin
						idx_q   <= HEX_LAST;
						state_q <= S_DIGITS;
					end
				end
				S_DIGITS: begin
					if (skip) begin
						idx_q <= idx_q - 1'b1;
					end else if (sts.out_free) begin
						started_q <= 1'b1;
						if (idx_q == 4'd0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				S_BYTE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PCT: begin
					if (sts.out_free) begin
						state_q <= sts.byte_zero ? S_IDLE : S_BYTE;
					end
				end
				S_NULL: begin
					if (sts.out_free) begin
						if (pos_q == NULL_LAST) begin
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_END: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FOC_NEVER(a_emit_needs_room, (ctl.emit || ctl.emit_end) && !sts.out_free)
	`FOC_ASSERT(a_one_action, $onehot0({ctl.load, ctl.bcd_step, ctl.emit, ctl.emit_end}))
	`FOC_ASSERT(a_conv_exit, ((state_q == S_CONV) && (bit_q == BITS_LAST)) |=> ((state_q == S_MINUS) || (state_q == S_DIGITS)))

endmodule

`default_nettype wire

[hw/rtl/formatted_output_char_stream.sv]
// Top level of the formatted character stream: controller plus datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   request  | in_valid / in_ready    | command[2:0], value[31:0]
//   result   | out_valid / out_ready  | character[7:0], last, length[8:0]
//   config   | cfg_we (no wait)       | cfg_wdata[8:0] (output limit)
//
// One request is handled at a time; the next is taken once the previous one has placed
// its last character in the output register. A decimal request is accepted, converted by
// serial binary-to-BCD conversion, then steps through every digit position whether
// emitted or skipped, after a minus sign if negative. Hex emits 0 and x, then steps through
// its digit positions; other kinds emit their characters in turn. A stalled output holds
// the sequencer on its next character. Reset clears the count and output, limit 500.
`default_nettype none

module formatted_output_char_stream (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [foc_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [foc_pkg::CMD_W-1:0]   command,
	input  logic [foc_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [foc_pkg::CHAR_W-1:0]  character,
	output logic                        last,
	output logic [foc_pkg::COUNT_W-1:0] length
);
	import foc_pkg::*;

	foc_ctl_t ctl;
	foc_sts_t sts;

	foc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.sts      (sts),
		.ctl      (ctl)
	);

	foc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.command   (command),
		.value     (value),
		.out_ready (out_ready),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.character (character),
		.last      (last),
		.length    (length)
	);

endmodule

`default_nettype wire

[test/formatted_output_char_stream_tb.sv]
// Self-checking testbench for formatted_output_char_stream: directed table, random messages, idling and back-pressure.
module formatted_output_char_stream_tb;
	import foc_pkg::*;

	localparam int unsigned STUCK_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 120;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam int unsigned NUM_PHASES = 8;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic               fin;
		logic [COUNT_W-1:0] len;
	} out_char_t;

	typedef struct packed {
		logic               wr;
		logic [COUNT_W-1:0] lim;
		cmd_t               c;
		logic [VALUE_W-1:0] v;
		logic               typed;
		logic [CHAR_W-1:0]  ch;
		logic [COUNT_W-1:0] len;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [COUNT_W-1:0]   cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     command;
	logic [VALUE_W-1:0]   value;
	logic                 out_valid;
	logic                 out_ready;
	logic [CHAR_W-1:0]    character;
	logic                 last;
	logic [COUNT_W-1:0]   length;

	out_char_t          pending_chars[$];
	out_char_t          item_chars[$];
	logic [COUNT_W-1:0] msg_count;
	logic [COUNT_W-1:0] cur_limit;
	bit                 check_failed;
	int unsigned        in_idle_pct;
	int unsigned        out_stall_pct;
	int unsigned        hold_cycles;
	int unsigned        stuck_cycles;

	dir_row_t directed_rows[] = '{
		'{1'b0, 9'd0,   CMD_LITERAL,  32'h0000_0041, 1'b1, 8'h41, 9'd1},
		'{1'b0, 9'd0,   CMD_LITERAL,  32'h0000_0000, 1'b1, 8'h00, 9'd2},
		'{1'b0, 9'd0,   CMD_LITERAL,  32'hFFFF_FFFF, 1'b1, 8'hFF, 9'd3},
		'{1'b0, 9'd0,   CMD_CHAR,     32'h5A5A_5A00, 1'b1, 8'h00, 9'd4},
		'{1'b0, 9'd0,   CMD_CHAR,     32'h0000_007A, 1'b1, 8'h7A, 9'd5},
		'{1'b0, 9'd0,   CMD_END,      32'hFFFF_FFFF, 1'b1, 8'h00, 9'd5},
		'{1'b0, 9'd0,   CMD_UNKNOWN,  32'hABCD_EF00, 1'b1, 8'h25, 9'd1},
		'{1'b0, 9'd0,   CMD_SIGNED,   32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_SIGNED,   32'h8000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_SIGNED,   32'h7FFF_FFFF, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_SIGNED,   32'hFFFF_FFFF, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_UNSIGNED, 32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_UNSIGNED, 32'hFFFF_FFFF, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_HEX,      32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_HEX,      32'hFFFF_FFFF, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_HEX,      32'h0123_ABCD, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_UNKNOWN,  32'h1234_5671, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_NULL,     32'h5555_AAAA, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_END,      32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b1, 9'd0,   CMD_END,      32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_UNSIGNED, 32'd12345,     1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_NULL,     32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_END,      32'h0000_0000, 1'b1, 8'h00, 9'd0},
		'{1'b1, 9'd3,   CMD_END,      32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_NULL,     32'h0000_0000, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_HEX,      32'hDEAD_BEEF, 1'b0, 8'h00, 9'd0},
		'{1'b0, 9'd0,   CMD_END,      32'h0000_0000, 1'b1, 8'h00, 9'd3}
	};

	formatted_output_char_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last),
		.length    (length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void put_char(input logic [CHAR_W-1:0] ch);
		if (msg_count < cur_limit) begin
			msg_count = msg_count + 9'd1;
			item_chars.push_back('{ch, 1'b0, msg_count});
		end
	endfunction

	function automatic void put_decimal(input logic [VALUE_W-1:0] mag);
		logic [CHAR_W-1:0] digs[10];
		int n;
		int i;
		n = 0;
		do begin
			digs[n] = CH_ZERO + 8'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		for (i = n - 1; i >= 0; i--) begin
			put_char(digs[i]);
		end
	endfunction

	function automatic void put_hex(input logic [VALUE_W-1:0] v);
		logic [CHAR_W-1:0] digs[8];
		logic [3:0] nib;
		int n;
		int i;
		n = 0;
		do begin
			nib = v[3:0];
			digs[n] = (nib < 4'd10) ? CH_ZERO + {4'h0, nib} : 8'h61 + {4'h0, nib} - 8'd10;
			v = v >> 4;
			n++;
		end while (v != 0);
		put_char(CH_ZERO);
		put_char(CH_X);
		for (i = n - 1; i >= 0; i--) begin
			put_char(digs[i]);
		end
	endfunction

	function automatic void format_request(input cmd_t c, input logic [VALUE_W-1:0] v);
		string null_text;
		int i;
		null_text = "(null)";
		item_chars.delete();
		case (c)
			CMD_LITERAL, CMD_CHAR: begin
				put_char(v[7:0]);
			end
			CMD_SIGNED: begin
				if (v[31]) begin
					put_char(CH_MINUS);
					put_decimal((~v) + 32'd1);
				end else begin
					put_decimal(v);
				end
			end
			CMD_UNSIGNED: begin
				put_decimal(v);
			end
			CMD_HEX: begin
				put_hex(v);
			end
			CMD_UNKNOWN: begin
				put_char(CH_PERCENT);
				if (v[7:0] != 8'h00) begin
					put_char(v[7:0]);
				end
			end
			CMD_NULL: begin
				for (i = 0; i < 6; i++) begin
					put_char(null_text[i]);
				end
			end
			default: begin
				item_chars.push_back('{CH_NUL, 1'b0, msg_count});
				msg_count = '0;
			end
		endcase
		if (item_chars.size() > 0) begin
			item_chars[item_chars.size() - 1].fin = 1'b1;
		end
		foreach (item_chars[k]) begin
			pending_chars.push_back(item_chars[k]);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] p;
		int e;
		case ($urandom_range(5))
			0: return $urandom_range(9);
			1: return $urandom;
			2: return {$urandom_range(1) ? 24'hFFFFFF : 24'h000000, 8'($urandom)};
			3: begin
				case ($urandom_range(4))
					0: return 32'h0000_0000;
					1: return 32'h8000_0000;
					2: return 32'h7FFF_FFFF;
					3: return 32'hFFFF_FFFF;
					default: return 32'h8000_0001;
				endcase
			end
			4: return {24'($urandom), 8'($urandom_range(8'h7E, 8'h20))};
			default: begin
				p = 32'd1;
				e = $urandom_range(9);
				repeat (e) p = p * 32'd10;
				return p - 32'($urandom_range(1));
			end
		endcase
	endfunction

	task automatic send_request(input cmd_t c, input logic [VALUE_W-1:0] v);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		format_request(c, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chars.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [COUNT_W-1:0] lim);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_limit = lim;
	endtask

	initial begin
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
			@(posedge clk);
		end
	end

	initial begin
		out_char_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected character %h length %0d", character, length);
					check_failed = 1'b1;
				end else begin
					want = pending_chars.pop_front();
					if (character !== want.ch) begin
						$error("character: expected %h, got %h", want.ch, character);
						check_failed = 1'b1;
					end
					if (last !== want.fin) begin
						$error("last: expected %b, got %b", want.fin, last);
						check_failed = 1'b1;
					end
					if (length !== want.len) begin
						$error("length: expected %0d, got %0d", want.len, length);
						check_failed = 1'b1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int r;
		int ph;
		int n;
		cmd_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		command = '0;
		value = '0;
		out_ready = 1'b0;
		msg_count = '0;
		cur_limit = LIMIT_RESET;
		check_failed = 1'b0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_cycles = 0;
		stuck_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < directed_rows.size(); r++) begin
			if (directed_rows[r].wr) begin
				set_limit(directed_rows[r].lim);
			end else begin
				send_request(directed_rows[r].c, directed_rows[r].v);
				if (directed_rows[r].typed) begin
					void'(pending_chars.pop_back());
					pending_chars.push_back('{directed_rows[r].ch, 1'b1, directed_rows[r].len});
				end
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_limit(9'd511);
				1: set_limit(9'd1);
				2: set_limit(9'd20);
				3: set_limit(LIMIT_RESET);
				5: set_limit(9'd511);
				6: set_limit(9'd60);
				default: set_limit(9'($urandom_range(511, 1)));
			endcase
			case (ph % 4)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct = 69;
					out_stall_pct = 0;
				end
				2: begin
					in_idle_pct = 0;
					out_stall_pct = 69;
				end
				default: begin
					in_idle_pct = 33;
					out_stall_pct = 33;
				end
			endcase
			// Hold the output off long enough that the block backs up into the request side.
			if (ph == 0) begin
				hold_cycles = 400;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 12 || n == PHASE_ITEMS - 1) begin
					c = CMD_END;
				end else begin
					c = cmd_t'($urandom_range(6));
				end
				send_request(c, pick_value());
			end
		end

		wait_drained();
		if (!check_failed) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
